// ===== hw/rtl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Character codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DIV   = 8'd47;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_MOD   = 8'd37;
    localparam logic [7:0] CH_POW   = 8'd94;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NUL   = 8'd0;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LEFT,
        S_OPS,
        S_ITER,
        S_FIN,
        S_OUT
    } state_t;

endpackage

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a reverse Polish expression presented one character per request.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (char_code, end_marker with
// valid/ready). Blanks and NUL are skipped, digits are pushed, operators
// pop two operands and push the result. Only an end request produces a
// response on the output channel: the top of stack and the first error
// status of the expression; the stack and status are then cleared.
// The operand stack lives in a synchronous simple dual-port memory with a
// registered read port. The entry written last is forwarded from a register
// so that a request straight after a push sees the new top of stack.
// Blanks and digits are handled in the idle state. An operator for + - *
// passes a left-read state and an operate state (two stack reads and a
// write); / % and ^ go on through a shared 32-step unit (restoring divider or
// square-and-multiply), one step per cycle, then a finish state. The response
// to an end request follows in the next cycle and is held until it is taken.
// While the response waits in the output register the block keeps taking
// character requests; a second end request waits until the first response
// is taken. Reset empties the stack, clears the status and the halt flag;
// the memory contents need no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         char_code,
    input  logic               end_marker,
    input  logic               in_valid,
    output logic               in_ready,
    output logic signed [31:0] value,
    output logic [2:0]         status,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);

    // Operand stack memory.
    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   rd_data_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [31:0]   wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    state_t        state_reg, state_next;
    logic [PW-1:0] sp_reg;
    logic [2:0]    err_reg;
    logic          halted_reg;
    logic [7:0]    op_reg;
    logic          r_ok_reg;   // right operand was present
    logic          l_ok_reg;
    logic [31:0]   right_reg;
    logic [31:0]   left_reg;
    logic [5:0]    cnt_reg;
    // Shared iterative unit: divider (rem/quo) or power (acc/base/expo).
    logic [31:0]   acc_reg;    // remainder or power accumulator
    logic [31:0]   quo_reg;    // quotient or exponent
    logic [31:0]   base_reg;   // divisor magnitude or squared base
    logic [31:0]   out_value_reg;
    logic [2:0]    out_status_reg;
    logic          out_valid_reg;
    logic          end_pend;
    // The registered read data misses a word just written; the written word stands in.
    logic          fwd_valid_reg;
    logic [31:0]   fwd_data_reg;
    logic [31:0]   top;

    logic acc_in;
    assign in_ready  = (state_reg == S_IDLE) && !(end_marker && out_valid_reg);
    assign acc_in    = in_valid && in_ready;
    assign value     = out_value_reg;
    assign status    = out_status_reg;
    assign out_valid = out_valid_reg;
    assign end_pend  = 1'b0;
    assign top       = fwd_valid_reg ? fwd_data_reg : rd_data_reg;

    logic is_blank, is_digit, is_div, is_pow, is_known;
    assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB) || (char_code == CH_NUL);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_div   = (op_reg == CH_DIV) || (op_reg == CH_MOD);
    assign is_pow   = (op_reg == CH_POW);
    assign is_known = (op_reg == CH_PLUS) || (op_reg == CH_MINUS) || (op_reg == CH_MUL)
                      || is_div || is_pow;

    logic sp_empty, sp_full, sp1_empty;
    assign sp_empty  = (sp_reg == '0);
    assign sp_full   = (sp_reg >= DEPTH_P);
    assign sp1_empty = (sp_reg <= PW'(1));

    logic [31:0] rv, lv;
    assign rv = r_ok_reg ? right_reg : 32'd0;
    assign lv = l_ok_reg ? rd_data_reg : 32'd0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_in && !end_marker && !halted_reg && !is_blank && !is_digit)
                begin
                    state_next = S_RD_LEFT;
                end
            end
            S_RD_LEFT: state_next = S_OPS;
            S_OPS:
            begin
                if (is_known && (is_div || is_pow))
                begin
                    state_next = S_ITER;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ITER:    state_next = (cnt_reg == 6'd31) ? S_FIN : S_ITER;
            S_FIN:     state_next = S_IDLE;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Memory addressing. The read address tracks the top entry so that the
    // registered read data is ready for the next request. While the left
    // operand is fetched the pointer already sits on it.
    logic [PW-1:0] sp_m1, sp_m2;
    assign sp_m1 = sp_reg - PW'(1);
    assign sp_m2 = sp_reg - PW'(2);

    logic [31:0] fin_res;
    logic        fin_push;

    always_comb
    begin
        raddr = AW'(sp_m1);
        if (state_reg == S_RD_LEFT)
        begin
            raddr = AW'(sp_reg);
        end
        we    = 1'b0;
        waddr = AW'(sp_reg);
        wdata = fin_res;
        if (state_reg == S_IDLE && acc_in && !end_marker && !halted_reg && is_digit && !sp_full)
        begin
            we    = 1'b1;
            wdata = {24'd0, char_code - CH_ZERO};
        end
        else if (fin_push && !sp_full)
        begin
            we = 1'b1;
        end
    end

    // Results of the quick operators and the iterative unit.
    logic        neg_q, neg_r;
    logic [31:0] mul_res;
    assign mul_res = lv * rv;
    always_comb
    begin
        fin_push = 1'b0;
        fin_res  = 32'd0;
        if (state_reg == S_OPS && is_known && !is_div && !is_pow)
        begin
            fin_push = 1'b1;
            case (op_reg)
                CH_PLUS:  fin_res = lv + rv;
                CH_MINUS: fin_res = lv - rv;
                default:  fin_res = mul_res;
            endcase
        end
        else if (state_reg == S_FIN)
        begin
            fin_push = 1'b1;
            if (is_pow)
            begin
                fin_res = acc_reg;
            end
            else if (right_reg == 32'd0)
            begin
                fin_res = 32'd0;
            end
            else if (op_reg == CH_DIV)
            begin
                fin_res = neg_q ? -quo_reg : quo_reg;
            end
            else
            begin
                fin_res = neg_r ? -acc_reg : acc_reg;
            end
        end
    end
    assign neg_q = left_reg[31] ^ right_reg[31];
    assign neg_r = left_reg[31];

    logic [32:0] trial;
    logic [31:0] dshift;
    assign dshift = {acc_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, dshift} - {1'b0, base_reg};

    logic [31:0] lmag, rmag;
    assign lmag = lv[31] ? -lv : lv;
    assign rmag = rv[31] ? -rv : rv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fwd_valid_reg <= we;
            fwd_data_reg  <= wdata;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc_in && end_marker)
                    begin
                        out_value_reg  <= sp_empty ? 32'd0 : top;
                        out_status_reg <= err_reg;
                        out_valid_reg  <= 1'b1;
                        sp_reg         <= '0;
                        err_reg        <= ST_OK;
                        halted_reg     <= 1'b0;
                    end
                    else if (acc_in && !halted_reg && is_digit)
                    begin
                        if (sp_full)
                        begin
                            if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                        end
                        else
                        begin
                            sp_reg <= sp_reg + PW'(1);
                        end
                    end
                    else if (acc_in && !halted_reg && !is_blank)
                    begin
                        op_reg    <= char_code;
                        right_reg <= top;
                        r_ok_reg  <= !sp_empty;
                        l_ok_reg  <= !sp1_empty;
                        if (sp1_empty && err_reg == ST_OK) err_reg <= ST_UNDERFLOW;
                        sp_reg <= sp1_empty ? '0 : sp_m2;
                    end
                end
                S_RD_LEFT: ;
                S_OPS:
                begin
                    right_reg <= rv;
                    left_reg  <= lv;
                    cnt_reg   <= 6'd0;
                    if (!is_known)
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_UNKNOWN;
                        halted_reg <= 1'b1;
                    end
                    else if (fin_push)
                    begin
                        if (sp_full)
                        begin
                            if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                        end
                        else
                        begin
                            sp_reg <= sp_reg + PW'(1);
                        end
                    end
                    if (is_pow)
                    begin
                        base_reg <= lv;
                        if (rv[31])
                        begin
                            // Negative exponent: the result is fixed here and
                            // the loop leaves it alone.
                            acc_reg <= (lv == 32'd1) ? 32'd1
                                     : (lv == 32'hFFFF_FFFF) ? (rv[0] ? 32'hFFFF_FFFF : 32'd1)
                                     : 32'd0;
                            quo_reg <= 32'd0;
                        end
                        else
                        begin
                            acc_reg <= 32'd1;
                            quo_reg <= rv;
                        end
                    end
                    else
                    begin
                        acc_reg  <= 32'd0;
                        quo_reg  <= lmag;
                        base_reg <= rmag;
                    end
                end
                S_ITER:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (is_pow)
                    begin
                        if (quo_reg[0]) acc_reg <= acc_reg * base_reg;
                        base_reg <= base_reg * base_reg;
                        quo_reg  <= {1'b0, quo_reg[31:1]};
                    end
                    else
                    begin
                        if (!trial[32])
                        begin
                            acc_reg <= trial[31:0];
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            acc_reg <= dshift;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                    end
                end
                S_FIN:
                begin
                    if (is_div && right_reg == 32'd0 && err_reg == ST_OK)
                    begin
                        err_reg <= ST_DIVZERO;
                    end
                    if (sp_full)
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                    end
                    else
                    begin
                        sp_reg <= sp_reg + PW'(1);
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Assertions.
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= DEPTH_P) else $error("stack pointer beyond depth");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && end_marker) |=> (sp_reg == '0 && err_reg == ST_OK && out_valid_reg))
        else $error("end request did not clear the expression");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accepted while busy");
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !(acc_in && end_marker)) |=> $stable(err_reg))
        else $error("status not sticky");
    a_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !end_pend) else $error("pending flag set");

endmodule
